### rtl/tcw_pkg.sv
// shared types and constants for the text console writer
package tcw_pkg;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h0F;
   localparam int         TAB_STOP     = 8;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic take;
      logic fill_init;
      logic fill_blank;
      logic copy_read;
      logic cnt_clear;
      logic cnt_inc;
      logic cnt_to_last_row;
      logic rsp_load;
      logic rsp_from_ram;
   } cmd_type;

   typedef struct packed {
      logic scroll_needed;
      logic cnt_copy_end;
      logic cnt_end;
      logic rsp_free;
   } status_type;

endpackage

### rtl/tcw_req_if.sv
// request channel of the text console writer
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] char_code;
   logic [4:0] read_row;
   logic [6:0] read_col;

   modport source (output valid, op, char_code, read_row, read_col, input ready);
   modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

### rtl/tcw_rsp_if.sv
// response channel of the text console writer
interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  cursor_row_out;
   logic [6:0]  cursor_col_out;
   logic [15:0] cell_data;

   modport source (output valid, cursor_row_out, cursor_col_out, cell_data, input ready);
   modport sink   (input valid, cursor_row_out, cursor_col_out, cell_data, output ready);
endinterface

### rtl/tcw_ram.sv
// generic single write, single read ram with registered read data
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/tcw_ctrl.sv
// controller state machine: request handshake and screen sweeps
module tcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_ready,
   input  tcw_pkg::status_type  status,
   output tcw_pkg::cmd_type     cmd
);

   tcw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            cmd.fill_init = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (status.cnt_end) begin
               cmd.cnt_clear = 1'b1;
               state_in      = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            req_ready = status.rsp_free;
            if (req_valid && status.rsp_free) begin
               cmd.take = 1'b1;
               case (tcw_pkg::op_type'(req_op))
                  tcw_pkg::OP_PUT: begin
                     if (status.scroll_needed) begin
                        cmd.cnt_clear = 1'b1;
                        state_in      = tcw_pkg::ST_COPY;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = tcw_pkg::ST_CLEAR;
                  end
                  tcw_pkg::OP_READ: begin
                     state_in = tcw_pkg::ST_READ;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_ram = 1'b1;
            state_in         = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_COPY: begin
            cmd.copy_read = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (status.cnt_copy_end) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            // last copy write lands here, then the bottom row is blanked
            cmd.cnt_to_last_row = 1'b1;
            state_in            = tcw_pkg::ST_FILL;
         end
         tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
            cmd.fill_blank = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.cnt_end) begin
               cmd.rsp_load = 1'b1;
               state_in     = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_INIT;
         end
      endcase
   end

endmodule

### rtl/tcw_datapath.sv
// datapath: cursor, attribute, sweep counter, screen store and response register
module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type status,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_char_code,
   input  logic [4:0]          req_read_row,
   input  logic [6:0]          req_read_col,
   input  logic                csr_write_en,
   input  logic [7:0]          csr_write_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [4:0]          rsp_cursor_row_out,
   output logic [6:0]          rsp_cursor_col_out,
   output logic [15:0]         rsp_cell_data
);

   localparam int CELLS      = ROWS * COLUMNS;
   localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);

   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [7:0]        attr_ff;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              copy_pend_ff;
   logic [ADDR_W-1:0] copy_dst_ff;
   logic              in_range_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [4:0]        rsp_row_ff;
   logic [6:0]        rsp_col_ff;
   logic [15:0]       rsp_cell_ff;

   logic [ROW_W:0]    row_t;
   logic [COL_W:0]    col_t;
   logic [ROW_W-1:0]  put_row;
   logic [COL_W-1:0]  put_col;
   logic              printable;
   logic              scroll;
   logic              is_put, is_clear, is_read;
   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] read_addr;
   logic              read_in_range;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;

   assign is_put   = tcw_pkg::op_type'(req_op) == tcw_pkg::OP_PUT;
   assign is_clear = tcw_pkg::op_type'(req_op) == tcw_pkg::OP_CLEAR;
   assign is_read  = tcw_pkg::op_type'(req_op) == tcw_pkg::OP_READ;

   // cursor motion for a put request
   always_comb begin
      row_t     = {1'b0, cursor_row_ff};
      col_t     = {1'b0, cursor_col_ff};
      printable = 1'b0;
      case (req_char_code)
         tcw_pkg::CH_NEWLINE: begin
            col_t = '0;
            row_t = row_t + 1'b1;
         end
         tcw_pkg::CH_TAB: begin
            col_t = (col_t + (COL_W+1)'(tcw_pkg::TAB_STOP))
                    & ~(COL_W+1)'(tcw_pkg::TAB_STOP - 1);
         end
         tcw_pkg::CH_RETURN: begin
            col_t = '0;
         end
         tcw_pkg::CH_BACKSPACE: begin
            if (col_t != '0) begin
               col_t = col_t - 1'b1;
            end
         end
         default: begin
            printable = 1'b1;
            col_t     = col_t + 1'b1;
         end
      endcase
      if (col_t >= (COL_W+1)'(COLUMNS)) begin
         col_t = '0;
         row_t = row_t + 1'b1;
      end
      scroll = row_t >= (ROW_W+1)'(ROWS);
      if (scroll) begin
         put_row = ROW_W'(ROWS - 1);
      end else begin
         put_row = row_t[ROW_W-1:0];
      end
      put_col = col_t[COL_W-1:0];
   end

   assign cursor_addr   = ADDR_W'(32'(cursor_row_ff) * COLUMNS + 32'(cursor_col_ff));
   assign read_addr     = ADDR_W'(32'(req_read_row) * COLUMNS + 32'(req_read_col));
   assign read_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);

   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      if (cmd.take && is_put) begin
         cursor_row_in = put_row;
         cursor_col_in = put_col;
      end else if (cmd.take && is_clear) begin
         cursor_row_in = '0;
         cursor_col_in = '0;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_to_last_row) begin
         cnt_in = ADDR_W'(COPY_CELLS);
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // one write port: pending scroll copy, fills, then a character
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      if (copy_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_dst_ff;
         wr_data = rd_data;
      end else if (cmd.fill_init) begin
         wr_en = 1'b1;
      end else if (cmd.fill_blank) begin
         wr_en   = 1'b1;
         wr_data = {attr_ff, tcw_pkg::BLANK_CHAR};
      end else if (cmd.take && is_put && printable) begin
         wr_en   = 1'b1;
         wr_addr = cursor_addr;
         wr_data = {attr_ff, req_char_code};
      end
   end

   assign rd_en   = cmd.copy_read || (cmd.take && is_read);
   assign rd_addr = cmd.copy_read ? cnt_ff + ADDR_W'(COLUMNS) : read_addr;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         attr_ff       <= tcw_pkg::RESET_ATTR;
         cnt_ff        <= '0;
         copy_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         if (csr_write_en) begin
            attr_ff <= csr_write_data;
         end
         cnt_ff       <= cnt_in;
         copy_pend_ff <= cmd.copy_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff <= cnt_ff;
      if (cmd.take) begin
         in_range_ff <= read_in_range;
      end
      if (cmd.rsp_load) begin
         rsp_row_ff <= 5'(cursor_row_in);
         rsp_col_ff <= 7'(cursor_col_in);
         if (cmd.rsp_from_ram && in_range_ff) begin
            rsp_cell_ff <= rd_data;
         end else begin
            rsp_cell_ff <= '0;
         end
      end
   end

   assign status.scroll_needed = scroll;
   assign status.cnt_copy_end  = cnt_ff == ADDR_W'(COPY_CELLS - 1);
   assign status.cnt_end       = cnt_ff == ADDR_W'(CELLS - 1);
   assign status.rsp_free      = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cell_data      = rsp_cell_ff;

endmodule

### rtl/text_console_writer_core.sv
// top level of the text console writer
// A text-mode console over a ROWS x COLUMNS store of 16-bit cells (attribute
// high byte, character low byte), kept in one single-write, single-read RAM.
// Each request gives exactly one response carrying the cursor after the
// request. A put that does not scroll, and an unused op, load their response
// in the cycle they are taken; a read loads it from ST_READ, since the RAM
// read data is registered. A put that runs past the last row scrolls the
// store: one cell is moved per cycle through the RAM ports, then the bottom
// row is blanked. A clear writes one cell per cycle. After reset the store
// is filled with blank 0x0F20 cells in a pass during which req_chan.ready
// stays low; csr writes are taken at any time. A new request is taken no
// earlier than the cycle in which the previous response is taken, so a
// stalled response stalls the request side as well.
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_chan,
   tcw_rsp_if.source  rsp_chan,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_chan.op),
      .req_char_code      (req_chan.char_code),
      .req_read_row       (req_chan.read_row),
      .req_read_col       (req_chan.read_col),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_cursor_row_out (rsp_chan.cursor_row_out),
      .rsp_cursor_col_out (rsp_chan.cursor_col_out),
      .rsp_cell_data      (rsp_chan.cell_data)
   );

   // a response is never loaded over one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("response overwritten before it was taken");

   // no request is taken while a sweep owns the screen store
   assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !(cmd.fill_init || cmd.fill_blank || cmd.copy_read))
      else $error("request offered during a screen sweep");

   // the initial blanking pass holds off requests
   assert property (@(posedge clock)
      reset |=> !req_chan.ready)
      else $error("request accepted before the blanking pass");

   // a read response is loaded in the cycle after its request is taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.take && (tcw_pkg::op_type'(req_chan.op) == tcw_pkg::OP_READ)
      |=> cmd.rsp_load && cmd.rsp_from_ram)
      else $error("read response not loaded on time");

endmodule

### tb/tb_text_console_writer_core.sv
// self-checking testbench for the text console writer core
module tb_text_console_writer_core;

   localparam int         COLUMNS     = 80;
   localparam int         ROWS        = 25;
   localparam int         CELLS       = ROWS * COLUMNS;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         PHASES      = 6;
   localparam int         PHASE_ITEMS = 300;
   localparam int         PRINT_LIMIT = 100;
   localparam longint     CYCLE_LIMIT = 16_000_000;

   typedef struct {
      logic [4:0]  row;
      logic [6:0]  col;
      logic [15:0] data;
   } console_view_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_write_en   = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   // shadow copy of the console: screen store, cursor and text attribute
   logic [15:0]      screen_model [CELLS];
   logic [4:0]       row_model;
   logic [6:0]       col_model;
   logic [7:0]       attr_model;
   console_view_type pending_views [$];

   int     error_count = 0;
   int     sent_count  = 0;
   longint cycle_count = 0;
   bit     no_gaps     = 1'b0;

   text_console_writer_core #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_bus),
      .rsp_chan      (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [15:0] blank_cell();
      return {attr_model, tcw_pkg::BLANK_CHAR};
   endfunction

   function automatic void fill_screen(input int first, input int count);
      for (int i = first; i < first + count; i++)
         screen_model[i] = blank_cell();
   endfunction

   // apply one request to the shadow console and return the response it gives
   function automatic console_view_type step_console(
      input logic [1:0] op, input logic [7:0] ch,
      input logic [4:0] rr, input logic [6:0] rc);
      console_view_type view;
      view.data = '0;
      case (op)
         tcw_pkg::OP_PUT: begin
            case (ch)
               tcw_pkg::CH_NEWLINE: begin
                  col_model = '0;
                  row_model = row_model + 1'b1;
               end
               tcw_pkg::CH_TAB:       col_model = (col_model + 7'd8) & ~7'd7;
               tcw_pkg::CH_RETURN:    col_model = '0;
               tcw_pkg::CH_BACKSPACE: if (col_model != 0) col_model = col_model - 1'b1;
               default: begin
                  screen_model[row_model * COLUMNS + col_model] = {attr_model, ch};
                  col_model = col_model + 1'b1;
               end
            endcase
            if (col_model >= COLUMNS) begin
               col_model = '0;
               row_model = row_model + 1'b1;
            end
            // past the last row: shift everything up one row
            if (row_model >= ROWS) begin
               for (int i = 0; i < CELLS - COLUMNS; i++)
                  screen_model[i] = screen_model[i + COLUMNS];
               fill_screen(CELLS - COLUMNS, COLUMNS);
               row_model = 5'(ROWS - 1);
            end
         end
         tcw_pkg::OP_CLEAR: begin
            fill_screen(0, CELLS);
            row_model = '0;
            col_model = '0;
         end
         tcw_pkg::OP_READ: begin
            if (rr < ROWS && rc < COLUMNS)
               view.data = screen_model[rr * COLUMNS + rc];
         end
         default: ;
      endcase
      view.row = row_model;
      view.col = col_model;
      return view;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      // keep the log short when everything goes wrong
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                               input logic [4:0] rr, input logic [6:0] rc);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.char_code <= ch;
      req_bus.read_row  <= rr;
      req_bus.read_col  <= rc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_views.push_back(step_console(op, ch, rr, rc));
      sent_count++;
      // switch between idling and back-to-back stretches now and then
      if (sent_count % 40 == 0)
         no_gaps = ($urandom_range(0, 3) == 0);
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_request(tcw_pkg::OP_PUT, ch, 5'($urandom_range(0, 31)),
                   7'($urandom_range(0, 127)));
   endtask

   task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
      send_request(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), rr, rc);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   task automatic set_attribute(input logic [7:0] value);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      attr_model = value;
      csr_write_en <= 1'b0;
   endtask

   task automatic test_reset_screen();
      read_cell(5'd0, 7'd0);
      read_cell(5'd24, 7'd79);
      // reads off the screen give zero
      read_cell(5'd25, 7'd0);
      read_cell(5'd31, 7'd127);
      read_cell(5'd0, 7'd80);
      send_request(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
   endtask

   task automatic test_control_chars();
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(tcw_pkg::CH_BACKSPACE);
      // backspace leaves the cell alone
      read_cell(5'd0, 7'd2);
      put_char(tcw_pkg::CH_RETURN);
      put_char(tcw_pkg::CH_BACKSPACE);
      put_char(tcw_pkg::CH_TAB);
      put_char(tcw_pkg::CH_TAB);
      put_char(tcw_pkg::CH_NEWLINE);
      read_cell(5'd0, 7'd0);
      read_cell(5'd0, 7'd1);
      send_request(tcw_pkg::OP_CLEAR, 8'h5A, 5'd3, 7'd3);
      read_cell(5'd0, 7'd0);
   endtask

   task automatic test_scroll();
      set_attribute(8'h00);
      put_char(8'h5A);
      repeat (ROWS - 1) put_char(tcw_pkg::CH_NEWLINE);
      put_char(8'h59);
      // tabs run off the end of the bottom row and scroll
      repeat (COLUMNS / tcw_pkg::TAB_STOP) put_char(tcw_pkg::CH_TAB);
      put_char(tcw_pkg::CH_NEWLINE);
      read_cell(5'd22, 7'd0);
      read_cell(5'd24, 7'd5);
      read_cell(5'd0, 7'd0);
   endtask

   task automatic test_random_traffic();
      int         pick;
      logic [7:0] ch;
      logic [4:0] rr;
      logic [6:0] rc;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_attribute(8'hFF);
            1:       set_attribute(8'h00);
            default: set_attribute(8'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            rr   = 5'($urandom_range(0, 31));
            rc   = 7'($urandom_range(0, 127));
            if (pick < 42)
               send_request(tcw_pkg::OP_PUT, ch, rr, rc);
            else if (pick < 48)
               send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, rr, rc);
            else if (pick < 52)
               send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, rr, rc);
            else if (pick < 56)
               send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, rr, rc);
            else if (pick < 61)
               send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, rr, rc);
            else if (pick < 75)
               // mostly look at the row being written
               send_request(tcw_pkg::OP_READ, ch, row_model,
                            7'($urandom_range(0, COLUMNS - 1)));
            else if (pick < 88)
               send_request(tcw_pkg::OP_READ, ch, 5'($urandom_range(0, ROWS - 1)),
                            7'($urandom_range(0, COLUMNS - 1)));
            else if (pick < 94)
               send_request(tcw_pkg::OP_READ, ch, rr, rc);
            else if (pick < 95)
               send_request(tcw_pkg::OP_CLEAR, ch, rr, rc);
            else
               send_request(OP_UNUSED, ch, rr, rc);
         end
      end
   endtask

   initial begin : response_check
      console_view_type want;
      int               hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_views.size() == 0) begin
               report_mismatch($sformatf("stray response: row %0d col %0d cell %h",
                                         rsp_bus.cursor_row_out, rsp_bus.cursor_col_out,
                                         rsp_bus.cell_data));
            end else begin
               want = pending_views.pop_front();
               if (rsp_bus.cursor_row_out !== want.row)
                  report_mismatch($sformatf("cursor row %0d, wanted %0d",
                                            rsp_bus.cursor_row_out, want.row));
               if (rsp_bus.cursor_col_out !== want.col)
                  report_mismatch($sformatf("cursor col %0d, wanted %0d",
                                            rsp_bus.cursor_col_out, want.col));
               if (rsp_bus.cell_data !== want.data)
                  report_mismatch($sformatf("cell data %h, wanted %h",
                                            rsp_bus.cell_data, want.data));
            end
            hold = no_gaps ? 0 : $urandom_range(0, 3);
         end else if (rsp_bus.valid && hold > 0) begin
            hold--;
         end
         rsp_bus.ready <= (hold == 0);
      end
   end

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.op        <= tcw_pkg::OP_PUT;
      req_bus.char_code <= 8'h00;
      req_bus.read_row  <= 5'd0;
      req_bus.read_col  <= 7'd0;
      attr_model = tcw_pkg::RESET_ATTR;
      row_model  = '0;
      col_model  = '0;
      fill_screen(0, CELLS);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_screen();
      test_control_chars();
      test_scroll();
      test_random_traffic();

      wait_drained();
      // room for a stray response after a full sweep of the store
      repeat (CELLS + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
